/* hw/rtl/fbc_pkg.sv */
// shared types and constants of the frustum box classifier
`timescale 1ns / 1ps
`default_nettype none

package fbc_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int COEF_W           = 16;
    localparam int NUM_PLANES       = 6;
    localparam int NUM_AXES         = 3;
    localparam int CFG_W            = 4 * COEF_W;
    localparam int PLANE_IDX_W      = 3;
    localparam int PROD_W           = COEF_W + COORD_WIDTH;
    localparam int DTERM_W          = COEF_W + NORMAL_FRAC_BITS;
    localparam int SUM_W            = ((PROD_W > DTERM_W) ? PROD_W : DTERM_W) + 2;
    localparam int LANE_STAGES      = 3;

    typedef enum logic [1:0] {
        VIS_NONE    = 2'd0,
        VIS_PARTIAL = 2'd1,
        VIS_FULL    = 2'd2
    } vis_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] d;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] a;
    } plane_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] high_z;
        logic signed [COORD_WIDTH-1:0] high_y;
        logic signed [COORD_WIDTH-1:0] high_x;
        logic signed [COORD_WIDTH-1:0] low_z;
        logic signed [COORD_WIDTH-1:0] low_y;
        logic signed [COORD_WIDTH-1:0] low_x;
    } box_t;

    typedef struct packed {
        logic all_behind;
        logic none_behind;
    } plane_flags_t;

endpackage

`default_nettype wire

/* hw/rtl/fbc_plane_regs.sv */
// plane coefficient register file
`timescale 1ns / 1ps
`default_nettype none

module fbc_plane_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [fbc_pkg::PLANE_IDX_W-1:0] wr_index,
    input  wire logic [fbc_pkg::CFG_W-1:0]       wr_data,
    output fbc_pkg::plane_t                      planes [fbc_pkg::NUM_PLANES]
);
    import fbc_pkg::*;

    logic [CFG_W-1:0] plane_reg [NUM_PLANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                if (wr_en && (wr_index == PLANE_IDX_W'(i)))
                begin
                    plane_reg[i] <= wr_data;
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            planes[i] = plane_t'(plane_reg[i]);
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/fbc_plane_lane.sv */
// one plane lane: products, per-axis extremes, extreme sums
`timescale 1ns / 1ps
`default_nettype none

module fbc_plane_lane (
    input  wire logic            clk,
    input  wire fbc_pkg::plane_t plane,
    input  wire fbc_pkg::box_t   box,
    output fbc_pkg::plane_flags_t flags
);
    import fbc_pkg::*;

    logic signed [COEF_W-1:0]      coef  [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] lo    [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] hi    [NUM_AXES];

    logic signed [PROD_W-1:0] prod_lo_next [NUM_AXES];
    logic signed [PROD_W-1:0] prod_hi_next [NUM_AXES];
    logic signed [PROD_W-1:0] prod_lo_reg  [NUM_AXES];
    logic signed [PROD_W-1:0] prod_hi_reg  [NUM_AXES];
    logic signed [COEF_W-1:0] d1_reg;

    logic signed [PROD_W-1:0] min_next [NUM_AXES];
    logic signed [PROD_W-1:0] max_next [NUM_AXES];
    logic signed [PROD_W-1:0] min_reg  [NUM_AXES];
    logic signed [PROD_W-1:0] max_reg  [NUM_AXES];
    logic signed [COEF_W-1:0] d2_reg;

    logic signed [SUM_W-1:0] dterm;
    logic signed [SUM_W-1:0] smin_next;
    logic signed [SUM_W-1:0] smax_next;
    logic signed [SUM_W-1:0] smin_reg;
    logic signed [SUM_W-1:0] smax_reg;

    // stage 1: normal component times both box bounds, per axis
    always_comb
    begin
        coef[0] = plane.a;
        coef[1] = plane.b;
        coef[2] = plane.c;
        lo[0]   = box.low_x;
        lo[1]   = box.low_y;
        lo[2]   = box.low_z;
        hi[0]   = box.high_x;
        hi[1]   = box.high_y;
        hi[2]   = box.high_z;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            prod_lo_next[k] = PROD_W'(coef[k] * lo[k]);
            prod_hi_next[k] = PROD_W'(coef[k] * hi[k]);
        end
    end

    // stage 2: the plane value is separable, so corner extremes come per axis
    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            if (prod_lo_reg[k] < prod_hi_reg[k])
            begin
                min_next[k] = prod_lo_reg[k];
                max_next[k] = prod_hi_reg[k];
            end
            else
            begin
                min_next[k] = prod_hi_reg[k];
                max_next[k] = prod_lo_reg[k];
            end
        end
    end

    // stage 3: extreme sums with the scaled offset
    always_comb
    begin
        dterm     = SUM_W'(d2_reg) <<< NORMAL_FRAC_BITS;
        smin_next = SUM_W'(min_reg[0]) + SUM_W'(min_reg[1]) + SUM_W'(min_reg[2]) + dterm;
        smax_next = SUM_W'(max_reg[0]) + SUM_W'(max_reg[1]) + SUM_W'(max_reg[2]) + dterm;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            prod_lo_reg[k] <= prod_lo_next[k];
            prod_hi_reg[k] <= prod_hi_next[k];
            min_reg[k]     <= min_next[k];
            max_reg[k]     <= max_next[k];
        end
        d1_reg   <= plane.d;
        d2_reg   <= d1_reg;
        smin_reg <= smin_next;
        smax_reg <= smax_next;
    end

    assign flags.all_behind  = smax_reg[SUM_W-1];
    assign flags.none_behind = ~smin_reg[SUM_W-1];

endmodule

`default_nettype wire

/* hw/rtl/frustum_box_classify_top.sv */
// top level of the frustum box classifier
`timescale 1ns / 1ps
`default_nettype none

// Classifies an axis-aligned box against six frustum planes.
// Command channel: a box word is taken at each rising edge with start high and
// busy low. busy is never raised, so one box can be taken every cycle.
// Result channel: done is high for exactly one cycle with visibility valid
// (none, partial, full); results come out in the order the boxes went in.
// Products are registered at the accepting edge, then per-axis min/max, extreme
// sums and the classification register, which drives visibility while done is
// high.
// Throughput is one box per cycle, set by the six plane lanes, each with six
// 16 x 16 multipliers working on a new box every cycle.
// Plane registers are written through wr_en, wr_index, wr_data with no wait;
// indexes beyond the last plane are ignored. Write them only while no box is
// in flight.
// Reset clears all planes to zero (every box is then fully inside) and empties
// the pipeline; no done is raised until a box is taken after reset.
// The receiver cannot hold results off, so nothing in the pipeline ever stalls.
module frustum_box_classify_top (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    start,
    output logic                                         busy,
    input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0]  low_x,
    input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0]  low_y,
    input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0]  low_z,
    input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0]  high_x,
    input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0]  high_y,
    input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0]  high_z,
    output logic                                         done,
    output logic [1:0]                                   visibility,
    input  wire logic                                    wr_en,
    input  wire logic [fbc_pkg::PLANE_IDX_W-1:0]         wr_index,
    input  wire logic [fbc_pkg::CFG_W-1:0]               wr_data
);
    import fbc_pkg::*;

    plane_t       planes [NUM_PLANES];
    plane_flags_t flags  [NUM_PLANES];
    box_t         box;

    logic [LANE_STAGES-1:0] valid_reg;
    logic [LANE_STAGES-1:0] valid_next;
    logic                   done_reg;
    vis_t                   vis_reg;
    vis_t                   vis_next;
    logic                   outside;
    logic                   full;

    assign busy = 1'b0;

    assign box.low_x  = low_x;
    assign box.low_y  = low_y;
    assign box.low_z  = low_z;
    assign box.high_x = high_x;
    assign box.high_y = high_y;
    assign box.high_z = high_z;

    fbc_plane_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .planes   (planes)
    );

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_lane
        fbc_plane_lane u_lane (
            .clk   (clk),
            .plane (planes[p]),
            .box   (box),
            .flags (flags[p])
        );
    end

    always_comb
    begin
        outside = 1'b0;
        full    = 1'b1;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            outside = outside | flags[p].all_behind;
            full    = full & flags[p].none_behind;
        end
        priority if (outside)
        begin
            vis_next = VIS_NONE;
        end
        else if (full)
        begin
            vis_next = VIS_FULL;
        end
        else
        begin
            vis_next = VIS_PARTIAL;
        end
        valid_next = {valid_reg[LANE_STAGES-2:0], start & ~busy};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= valid_reg[LANE_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        vis_reg <= vis_next;
    end

    assign done       = done_reg;
    assign visibility = vis_reg;

endmodule

`default_nettype wire

/* tb/frustum_box_classify_checker.sv */
// checker for the frustum box classifier: predicts visibility per box and compares results
`timescale 1ns / 1ps

module frustum_box_classify_checker (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    start,
    input  wire logic                                    busy,
    input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0]  low_x,
    input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0]  low_y,
    input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0]  low_z,
    input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0]  high_x,
    input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0]  high_y,
    input  wire logic signed [fbc_pkg::COORD_WIDTH-1:0]  high_z,
    input  wire logic                                    done,
    input  wire logic [1:0]                              visibility,
    input  wire logic                                    wr_en,
    input  wire logic [fbc_pkg::PLANE_IDX_W-1:0]         wr_index,
    input  wire logic [fbc_pkg::CFG_W-1:0]               wr_data,
    output int                                           fail_count,
    output int                                           pending
);
    import fbc_pkg::*;

    localparam int CORNERS = 8;

    plane_t planes [NUM_PLANES];
    vis_t   expected_vis [$];
    int     errors;

    function automatic vis_t classify_box(box_t bx);
        longint lo [NUM_AXES];
        longint hi [NUM_AXES];
        longint px;
        longint py;
        longint pz;
        longint plane_val;
        int     behind;
        int     clear_planes;
        bit     culled;
        lo[0] = longint'($signed(bx.low_x));
        lo[1] = longint'($signed(bx.low_y));
        lo[2] = longint'($signed(bx.low_z));
        hi[0] = longint'($signed(bx.high_x));
        hi[1] = longint'($signed(bx.high_y));
        hi[2] = longint'($signed(bx.high_z));
        culled = 1'b0;
        clear_planes = 0;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            behind = 0;
            for (int k = 0; k < CORNERS; k++)
            begin
                px = k[2] ? hi[0] : lo[0];
                py = k[1] ? hi[1] : lo[1];
                pz = k[0] ? hi[2] : lo[2];
                plane_val = longint'($signed(planes[p].a)) * px
                          + longint'($signed(planes[p].b)) * py
                          + longint'($signed(planes[p].c)) * pz
                          + (longint'($signed(planes[p].d)) <<< NORMAL_FRAC_BITS);
                if (plane_val < 0)
                    behind++;
            end
            if (behind == CORNERS)
                culled = 1'b1;
            else if (behind == 0)
                clear_planes++;
        end
        if (culled)
            return VIS_NONE;
        if (clear_planes == NUM_PLANES)
            return VIS_FULL;
        return VIS_PARTIAL;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        box_t bx;
        vis_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
                planes[i] = '0;
            expected_vis.delete();
            errors = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_vis.size() == 0)
                begin
                    $error("visibility: expected none outstanding, actual %0d", visibility);
                    errors++;
                end
                else
                begin
                    want = expected_vis.pop_front();
                    if (visibility !== want)
                    begin
                        $error("visibility: expected %0d, actual %0d", want, visibility);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                bx.low_x  = low_x;
                bx.low_y  = low_y;
                bx.low_z  = low_z;
                bx.high_x = high_x;
                bx.high_y = high_y;
                bx.high_z = high_z;
                expected_vis.push_back(classify_box(bx));
            end
            if (wr_en && wr_index < NUM_PLANES)
                planes[wr_index] = wr_data;
            fail_count <= errors;
            pending <= expected_vis.size();
        end
    end

endmodule

/* tb/frustum_box_classify_top_tb.sv */
// testbench top for the frustum box classifier: stimulus, plane loading and verdict
`timescale 1ns / 1ps

module frustum_box_classify_top_tb;
    import fbc_pkg::*;

    localparam int LATENCY       = 4;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 95;
    localparam int UNIT_NORMAL   = 1 << NORMAL_FRAC_BITS;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic signed [COORD_WIDTH-1:0] low_x;
    logic signed [COORD_WIDTH-1:0] low_y;
    logic signed [COORD_WIDTH-1:0] low_z;
    logic signed [COORD_WIDTH-1:0] high_x;
    logic signed [COORD_WIDTH-1:0] high_y;
    logic signed [COORD_WIDTH-1:0] high_z;
    logic                          done;
    logic [1:0]                    visibility;
    logic                          wr_en;
    logic [PLANE_IDX_W-1:0]        wr_index;
    logic [CFG_W-1:0]              wr_data;

    int     fail_count;
    int     pending;
    int     stall_cycles = 0;
    plane_t plane_set [NUM_PLANES];

    frustum_box_classify_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .low_x      (low_x),
        .low_y      (low_y),
        .low_z      (low_z),
        .high_x     (high_x),
        .high_y     (high_y),
        .high_z     (high_z),
        .done       (done),
        .visibility (visibility),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    frustum_box_classify_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .low_x      (low_x),
        .low_y      (low_y),
        .low_z      (low_z),
        .high_x     (high_x),
        .high_y     (high_y),
        .high_z     (high_z),
        .done       (done),
        .visibility (visibility),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    function automatic plane_t mk_plane(int a, int b, int c, int d);
        plane_t p;
        p.a = 16'(a);
        p.b = 16'(b);
        p.c = 16'(c);
        p.d = 16'(d);
        return p;
    endfunction

    function automatic box_t mk_box(int lx, int ly, int lz, int hx, int hy, int hz);
        box_t bx;
        bx.low_x  = 16'(lx);
        bx.low_y  = 16'(ly);
        bx.low_z  = 16'(lz);
        bx.high_x = 16'(hx);
        bx.high_y = 16'(hy);
        bx.high_z = 16'(hz);
        return bx;
    endfunction

    function automatic box_t rand_box();
        int kind;
        int ctr [3];
        int half [3];
        kind = $urandom_range(99);
        if (kind < 20)
            return mk_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        for (int k = 0; k < 3; k++)
        begin
            ctr[k] = int'($urandom_range(8000)) - 4000;
            half[k] = (kind < 30) ? 0 : int'($urandom_range(2000));
        end
        // inverted boxes keep the corners as given
        if (kind < 40 && kind >= 30)
            return mk_box(ctr[0] + half[0], ctr[1] + half[1], ctr[2] + half[2],
                          ctr[0] - half[0], ctr[1] - half[1], ctr[2] - half[2]);
        return mk_box(ctr[0] - half[0], ctr[1] - half[1], ctr[2] - half[2],
                      ctr[0] + half[0], ctr[1] + half[1], ctr[2] + half[2]);
    endfunction

    // left, top, right, bottom, near, far
    task automatic build_planes(input int style);
        int axis_of [NUM_PLANES];
        int sign_of [NUM_PLANES];
        int comps [3];
        axis_of = '{0, 1, 0, 1, 2, 2};
        sign_of = '{1, -1, -1, 1, 1, -1};
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            if (style == 2)
                plane_set[i] = {$urandom, $urandom};
            else
            begin
                for (int k = 0; k < 3; k++)
                    comps[k] = (style == 1) ? int'($urandom_range(8000)) - 4000 : 0;
                comps[axis_of[i]] = sign_of[i] *
                    ((style == 1) ? int'($urandom_range(UNIT_NORMAL, 8000)) : UNIT_NORMAL);
                plane_set[i] = mk_plane(comps[0], comps[1], comps[2],
                                        int'($urandom_range(3000)));
            end
        end
    endtask

    task automatic set_cube(input int half);
        plane_set[0] = mk_plane(UNIT_NORMAL, 0, 0, half);
        plane_set[1] = mk_plane(0, -UNIT_NORMAL, 0, half);
        plane_set[2] = mk_plane(-UNIT_NORMAL, 0, 0, half);
        plane_set[3] = mk_plane(0, UNIT_NORMAL, 0, half);
        plane_set[4] = mk_plane(0, 0, UNIT_NORMAL, half);
        plane_set[5] = mk_plane(0, 0, -UNIT_NORMAL, half);
    endtask

    task automatic write_reg(input int idx, input logic [CFG_W-1:0] data);
        wr_en <= 1'b1;
        wr_index <= idx[PLANE_IDX_W-1:0];
        wr_data <= data;
        @(posedge clk);
    endtask

    // indexes past the last plane must be ignored
    task automatic load_planes(input bit with_spare);
        for (int i = 0; i < NUM_PLANES; i++)
            write_reg(i, plane_set[i]);
        if (with_spare)
        begin
            write_reg(NUM_PLANES, {CFG_W{1'b1}});
            write_reg(NUM_PLANES + 1, {$urandom, $urandom});
        end
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_box(input box_t bx);
        start <= 1'b1;
        low_x <= bx.low_x;
        low_y <= bx.low_y;
        low_z <= bx.low_z;
        high_x <= bx.high_x;
        high_y <= bx.high_y;
        high_z <= bx.high_z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic sender_gap(input int pct);
        while (int'($urandom_range(99)) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    initial
    begin
        int idle_pct;
        rst_n = 1'b0;
        start = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        low_x = '0;
        low_y = '0;
        low_z = '0;
        high_x = '0;
        high_y = '0;
        high_z = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // planes cleared by reset: every box fully inside
        send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        settle();

        set_cube(1000);
        load_planes(1'b0);
        send_box(mk_box(-10, -10, -10, 10, 10, 10));
        send_box(mk_box(500, 0, 0, 1500, 10, 10));
        send_box(mk_box(1500, 0, 0, 1600, 10, 10));
        send_box(mk_box(-1000, -1000, -1000, 1000, 1000, 1000));
        send_box(mk_box(-1001, 0, 0, -1000, 0, 0));
        send_box(mk_box(-1001, 0, 0, -1001, 0, 0));
        send_box(mk_box(10, 10, 10, -10, -10, -10));
        send_box(mk_box(1500, 0, 0, -1500, 0, 0));
        send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        settle();

        for (int i = 0; i < NUM_PLANES - 1; i++)
            plane_set[i] = (i % 2 == 0) ? mk_plane(-32768, 32767, -32768, 32767)
                                        : mk_plane(32767, -32768, 32767, -32768);
        plane_set[NUM_PLANES-1] = mk_plane(0, 0, 0, 32767);
        load_planes(1'b1);
        send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        send_box(mk_box(-32768, 32767, -32768, 32767, -32768, 32767));
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            idle_pct = (ph < 3) ? 7 : ((ph < 6) ? 51 : 0);
            build_planes(ph % 3);
            load_planes($urandom_range(1));
            repeat (PHASE_ITEMS)
            begin
                sender_gap(idle_pct);
                send_box(rand_box());
            end
            settle();
        end

        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/fbc_pkg.sv
hw/rtl/fbc_plane_regs.sv
hw/rtl/fbc_plane_lane.sv
hw/rtl/frustum_box_classify_top.sv
tb/frustum_box_classify_checker.sv
tb/frustum_box_classify_top_tb.sv
